// ===== sv/utf8_glyph_sanitizer_defines.svh =====
// Assertion macros used by the RTL file ugs_back.sv.
`ifndef UTF8_GLYPH_SANITIZER_DEFINES_SVH
`define UTF8_GLYPH_SANITIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define UGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define UGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UGS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ugs_pkg.sv =====
`timescale 1ns / 1ps
package ugs_pkg;

  localparam int CpW        = 21;
  localparam int QueueDepth = 4;

  localparam logic [CpW-1:0] MinCp2    = 21'h000080;
  localparam logic [CpW-1:0] MinCp3    = 21'h000800;
  localparam logic [CpW-1:0] MinCp4    = 21'h010000;
  localparam logic [CpW-1:0] MaxCpExcl = 21'h10FFFF;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqTwo  = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour = 3'd4;

  // One decoded item handed from the decoder to the encoder.
  typedef struct packed {
    logic           term;
    logic [CpW-1:0] cp;
  } job_t;

  localparam logic [7:0] GlyphLow [16] = '{
    8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
    8'h23, 8'h09, 8'h0A, 8'h23, 8'h20, 8'h0D, 8'h2E, 8'h2E
  };
  localparam logic [7:0] GlyphHigh [16] = '{
    8'h3C, 8'h3D, 8'h3E, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h20, 8'h23, 8'h20, 8'h3E, 8'h2E, 8'h2E
  };
  localparam logic [7:0] GlyphRow1 [16] = '{
    8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
    8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E
  };

  // Map a code point below 256 to its printable byte, 0 = nothing.
  function automatic logic [7:0] glyph_rom(logic [7:0] c);
    logic [6:0] lo;
    logic [7:0] g;
    lo = c[6:0];
    if (lo[6:4] == 3'd0) begin
      g = c[7] ? GlyphHigh[lo[3:0]] : GlyphLow[lo[3:0]];
    end else if (lo[6:4] == 3'd1) begin
      g = GlyphRow1[lo[3:0]];
    end else if (lo == 7'h7F) begin
      g = 8'h3C;
    end else begin
      g = {1'b0, lo};
    end
    return g;
  endfunction

endpackage

// ===== sv/ugs_front.sv =====
`timescale 1ns / 1ps
module ugs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             full_i,
  output logic             push_o,
  output ugs_pkg::job_t    job_o
);

  logic [2:0]               exp_len_q, exp_len_d;
  logic [1:0]               cnt_q, cnt_d;
  logic [ugs_pkg::CpW-1:0]  code_q, code_d;
  logic                     accept;
  logic [ugs_pkg::CpW-1:0]  code_ext;
  logic [2:0]               cnt_inc;
  logic [ugs_pkg::CpW-1:0]  min_cp;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign code_ext   = {code_q[ugs_pkg::CpW-7:0], in_byte_i[5:0]};
  assign cnt_inc    = {1'b0, cnt_q} + 3'd1;

  always_comb begin
    case (exp_len_q)
      ugs_pkg::SeqTwo:   min_cp = ugs_pkg::MinCp2;
      ugs_pkg::SeqThree: min_cp = ugs_pkg::MinCp3;
      default:           min_cp = ugs_pkg::MinCp4;
    endcase
  end

  always_comb begin
    exp_len_d  = exp_len_q;
    cnt_d      = cnt_q;
    code_d     = code_q;
    push_o     = 1'b0;
    job_o.term = 1'b0;
    job_o.cp   = '0;
    if (accept) begin
      if (in_byte_i == 8'h00) begin
        exp_len_d  = ugs_pkg::SeqNone;
        cnt_d      = '0;
        code_d     = '0;
        push_o     = 1'b1;
        job_o.term = 1'b1;
      end else if (exp_len_q != ugs_pkg::SeqNone && in_byte_i[7:6] == 2'b10) begin
        if (cnt_inc < exp_len_q) begin
          // gather and wait for more continuation bytes
          cnt_d  = cnt_inc[1:0];
          code_d = code_ext;
        end else begin
          exp_len_d = ugs_pkg::SeqNone;
          cnt_d     = '0;
          code_d    = '0;
          if (code_ext >= min_cp && code_ext < ugs_pkg::MaxCpExcl) begin
            push_o = 1'b1;
            // fold the private-use row E0xx down onto 00xx
            if (code_ext[ugs_pkg::CpW-1:8] == 13'h00E0) begin
              job_o.cp = {13'h0000, code_ext[7:0]};
            end else begin
              job_o.cp = code_ext;
            end
          end
        end
      end else begin
        // drop any pending sequence, then treat the byte as a lead
        exp_len_d = ugs_pkg::SeqNone;
        cnt_d     = '0;
        code_d    = '0;
        if (in_byte_i < 8'h80) begin
          push_o   = 1'b1;
          job_o.cp = {13'h0000, in_byte_i};
        end else if (in_byte_i >= 8'hC2 && in_byte_i < 8'hE0) begin
          exp_len_d = ugs_pkg::SeqTwo;
          cnt_d     = 2'd1;
          code_d    = {16'h0000, in_byte_i[4:0]};
        end else if (in_byte_i >= 8'hE0 && in_byte_i < 8'hF0) begin
          exp_len_d = ugs_pkg::SeqThree;
          cnt_d     = 2'd1;
          code_d    = {17'h00000, in_byte_i[3:0]};
        end else if (in_byte_i >= 8'hF0 && in_byte_i < 8'hF5) begin
          exp_len_d = ugs_pkg::SeqFour;
          cnt_d     = 2'd1;
          code_d    = {18'h00000, in_byte_i[2:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= ugs_pkg::SeqNone;
      cnt_q     <= '0;
      code_q    <= '0;
    end else begin
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
      code_q    <= code_d;
    end
  end

endmodule

// ===== sv/ugs_queue.sv =====
`timescale 1ns / 1ps
module ugs_queue #(
  parameter int Depth = ugs_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ugs_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output ugs_pkg::job_t head_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ugs_pkg::job_t   slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/ugs_back.sv =====
`timescale 1ns / 1ps
`include "utf8_glyph_sanitizer_defines.svh"
module ugs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ugs_pkg::job_t head_job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o,
  output logic          string_end_o
);

  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        last_q, last_d;
  logic        end_q, end_d;
  logic [2:0]  n_bytes;
  logic [7:0]  enc [4];
  logic [7:0]  glyph;
  logic        load_en;
  logic        is_last;
  logic [ugs_pkg::CpW-1:0] cp;

  assign cp    = head_job_i.cp;
  assign glyph = ugs_pkg::glyph_rom(cp[7:0]);

  // Encode the head item into its output bytes.
  always_comb begin
    n_bytes = 3'd0;
    for (int i = 0; i < 4; i++) begin
      enc[i] = 8'h00;
    end
    if (head_job_i.term) begin
      n_bytes = 3'd1;
    end else if (cp[20:8] == 13'h0000) begin
      n_bytes = (glyph == 8'h00) ? 3'd0 : 3'd1;
      enc[0]  = glyph;
    end else if (cp[20:11] == 10'h000) begin
      n_bytes = 3'd2;
      enc[0]  = {3'b110, cp[10:6]};
      enc[1]  = {2'b10, cp[5:0]};
    end else if (cp[20:16] == 5'h00) begin
      n_bytes = 3'd3;
      enc[0]  = {4'b1110, cp[15:12]};
      enc[1]  = {2'b10, cp[11:6]};
      enc[2]  = {2'b10, cp[5:0]};
    end else begin
      n_bytes = 3'd4;
      enc[0]  = {5'b11110, cp[20:18]};
      enc[1]  = {2'b10, cp[17:12]};
      enc[2]  = {2'b10, cp[11:6]};
      enc[3]  = {2'b10, cp[5:0]};
    end
  end

  assign load_en = !out_valid_q || !out_stall_i;
  assign is_last = ({1'b0, idx_q} == n_bytes - 3'd1);

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    end_d       = end_q;
    pop_o       = 1'b0;
    if (load_en) begin
      out_valid_d = head_valid_i && (n_bytes != 3'd0);
      if (head_valid_i) begin
        if (n_bytes == 3'd0) begin
          // empty glyph: drop the item
          pop_o = 1'b1;
        end else begin
          out_byte_d = enc[idx_q];
          last_d     = is_last;
          end_d      = head_job_i.term;
          if (is_last) begin
            pop_o = 1'b1;
            idx_d = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    end_q      <= end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign string_end_o  = end_q;

  `UGS_ASSERT_IMP(a_end_is_last_zero, clk_i, rst_ni, out_valid_q && end_q, last_q && out_byte_q == 8'h00)
  `UGS_ASSERT_IMP(a_idx_within_item, clk_i, rst_ni, idx_q != 2'd0, head_valid_i && {1'b0, idx_q} < n_bytes)
  `UGS_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_q && !last_q && !out_stall_i, out_valid_q)

endmodule

// ===== sv/utf8_glyph_sanitizer.sv =====
`timescale 1ns / 1ps
// UTF-8 glyph sanitizer.
// Input channel: in_valid_i / in_stall_o / in_byte_i, one text byte per word;
// a zero byte ends the string. Output channel: out_valid_o / out_stall_i with
// out_byte_o, last_of_run_o (final byte caused by one input byte) and
// string_end_o (the terminating zero byte). A word moves when valid is high
// and stall is low.
// A decoder takes one byte per cycle and hands each complete code point (or
// the terminator) to a small queue; an encoder drains the queue and emits
// one output byte per cycle unless stalled. A byte goes through a queue slot
// and then the output register on its way out. ASCII and glyph-mapped text
// runs at one byte per cycle; a code point re-encoded as 2 to 4 bytes holds
// the encoder until all its bytes have left the single output register.
// The decoder only stalls when the queue (QDepth entries) is full.
// When out_stall_i is high the output word holds and the queue fills, after
// which in_stall_o rises. Reset clears the pending sequence, the queue and
// the output valid flag; the block is ready on the first cycle after reset.
module utf8_glyph_sanitizer #(
  parameter int QDepth = ugs_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       string_end_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  ugs_pkg::job_t push_job;
  ugs_pkg::job_t head_job;

  ugs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  ugs_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  ugs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_end_o  (string_end_o)
  );

endmodule

// ===== sim/utf8_glyph_sanitizer_test.sv =====
`timescale 1ns / 1ps
module utf8_glyph_sanitizer_test;

  typedef enum logic [2:0] {
    PACE_FREE,
    PACE_SEND_SPARSE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } out_word_t;

  localparam logic [20:0] CP_MIN2   = 21'h000080;
  localparam logic [20:0] CP_MIN3   = 21'h000800;
  localparam logic [20:0] CP_MIN4   = 21'h010000;
  localparam logic [20:0] CP_LIMIT  = 21'h10FFFF;
  localparam logic [20:0] PUA_BASE  = 21'h00E000;
  localparam logic [20:0] PUA_END   = 21'h00E100;
  localparam int          HOLD_CYCLES = 60;
  localparam int          TAIL_CYCLES = 8;
  localparam int          TIMEOUT_NS  = 4_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       string_end_o;

  utf8_glyph_sanitizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o),
    .string_end_o (string_end_o)
  );

  pace_e      pace = PACE_FREE;
  logic [7:0] text_bytes[$];
  out_word_t  words_due[$];
  logic       in_took = 1'b0;
  int         hold_cnt = 0;
  int         errors = 0;
  int         bytes_in = 0;
  int         words_out = 0;
  int         ends_seen = 0;
  int         wide_words = 0;

  // Decoder state of the predictor.
  int          seq_len = 0;
  int          seq_seen = 0;
  logic [20:0] seq_code = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] glyph_of(logic [7:0] c);
    logic [3:0] n;
    logic [7:0] g;
    n = c[3:0];
    if (c[6:4] == 3'd0 && !c[7]) begin
      case (n)
        4'd0:                     g = 8'h00;
        4'd5, 4'd14, 4'd15:       g = 8'h2E;
        4'd9:                     g = 8'h09;
        4'd10:                    g = 8'h0A;
        4'd12:                    g = 8'h20;
        4'd13:                    g = 8'h0D;
        default:                  g = 8'h23;
      endcase
    end else if (c[6:4] == 3'd0) begin
      case (n)
        4'd0:                     g = 8'h3C;
        4'd1:                     g = 8'h3D;
        4'd2, 4'd13:              g = 8'h3E;
        4'd5, 4'd14, 4'd15:       g = 8'h2E;
        4'd10, 4'd12:             g = 8'h20;
        default:                  g = 8'h23;
      endcase
    end else if (c[6:4] == 3'd1) begin
      case (n)
        4'd0:                     g = 8'h5B;
        4'd1:                     g = 8'h5D;
        4'd12:                    g = 8'h2E;
        4'd13:                    g = 8'h3C;
        4'd14:                    g = 8'h3D;
        4'd15:                    g = 8'h3E;
        default:                  g = 8'h30 + 8'(n - 4'd2);
      endcase
    end else if (c[6:0] == 7'h7F) begin
      g = 8'h3C;
    end else begin
      g = {1'b0, c[6:0]};
    end
    return g;
  endfunction

  task automatic emit_point(input logic [20:0] cp_in);
    logic [20:0] cp;
    logic [7:0]  enc[4];
    logic [7:0]  g;
    int          n;
    cp = cp_in;
    n = 0;
    if (cp >= PUA_BASE && cp < PUA_END) cp = cp - PUA_BASE;
    if (cp < 21'h000100) begin
      g = glyph_of(cp[7:0]);
      if (g == 8'h00) return;
      enc[0] = g;
      n = 1;
    end else if (cp < CP_MIN3) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < CP_MIN4) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      words_due.push_back('{data: enc[k], last: (k == n - 1), fin: 1'b0});
    end
  endtask

  task automatic clear_seq();
    seq_len = 0;
    seq_seen = 0;
    seq_code = '0;
  endtask

  // Work out the output words that one accepted text byte causes.
  task automatic decode_text_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    if (b == 8'h00) begin
      clear_seq();
      words_due.push_back('{data: 8'h00, last: 1'b1, fin: 1'b1});
      return;
    end
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_code = {seq_code[14:0], b[5:0]};
        seq_seen++;
        if (seq_seen < seq_len) return;
        cp = seq_code;
        floor_cp = (seq_len == 2) ? CP_MIN2 : (seq_len == 3) ? CP_MIN3 : CP_MIN4;
        clear_seq();
        if (cp >= floor_cp && cp < CP_LIMIT) emit_point(cp);
        return;
      end
      // drop the broken sequence and look at this byte as a new lead
      clear_seq();
    end
    if (b < 8'h80) begin
      emit_point({13'd0, b});
    end else if (b >= 8'hC2 && b < 8'hE0) begin
      seq_len = 2;
      seq_seen = 1;
      seq_code = {16'd0, b[4:0]};
    end else if (b >= 8'hE0 && b < 8'hF0) begin
      seq_len = 3;
      seq_seen = 1;
      seq_code = {17'd0, b[3:0]};
    end else if (b >= 8'hF0 && b < 8'hF5) begin
      seq_len = 4;
      seq_seen = 1;
      seq_code = {18'd0, b[2:0]};
    end
  endtask

  function automatic int send_idle_pct(pace_e p);
    case (p)
      PACE_SEND_SPARSE: return 84;
      PACE_BOTH:        return 19;
      default:          return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(pace_e p);
    case (p)
      PACE_RECV_STALL: return 84;
      PACE_BOTH:       return 19;
      default:         return 0;
    endcase
  endfunction

  // Sender: advance only when the current word was taken or none is offered.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(pace)) begin
        in_byte_i  <= text_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or one long hold-off at the start of the hold phase.
  always @(negedge clk_i) begin
    if (pace != PACE_HOLD) hold_cnt = 0;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (pace == PACE_HOLD && hold_cnt < HOLD_CYCLES) begin
      hold_cnt = hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct(pace));
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      bytes_in++;
      decode_text_byte(in_byte_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{data: out_byte_o, last: last_of_run_o, fin: string_end_o};
      words_out++;
      if (got.fin) ends_seen++;
      if (got.data[7]) wide_words++;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual byte=%02h last=%0b end=%0b",
                 $time, got.data, got.last, got.fin);
      end else begin
        want = words_due.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch: expected byte=%02h last=%0b end=%0b, actual byte=%02h last=%0b end=%0b",
                   $time, want.data, want.last, want.fin, got.data, got.last, got.fin);
        end
      end
    end
  end

  task automatic push_text(input logic [7:0] b);
    text_bytes.push_back(b);
  endtask

  // Bytes of a sequence of the given length, first byte in the top lane.
  function automatic logic [31:0] pack_seq(logic [20:0] cp, int len);
    case (len)
      1:       return {1'b0, cp[6:0], 24'd0};
      2:       return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
      3:       return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  task automatic push_first(input logic [31:0] seq, input int k);
    for (int i = 0; i < k; i++) push_text(seq[31 - 8 * i -: 8]);
  endtask

  task automatic add_chunk();
    int          pick;
    int          len;
    logic [20:0] cp;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    if (pick < 25) begin
      push_text(8'($urandom_range(1, 127)));
    end else if (pick < 40) begin
      push_first(pack_seq(21'($urandom_range(32'h80, 32'h7FF)), 2), 2);
    end else if (pick < 55) begin
      if ($urandom_range(0, 2) == 0) cp = PUA_BASE + 21'($urandom_range(0, 255));
      else cp = 21'($urandom_range(32'h800, 32'hFFFF));
      push_first(pack_seq(cp, 3), 3);
    end else if (pick < 67) begin
      push_first(pack_seq(21'($urandom_range(32'h10000, 32'h10FFFE)), 4), 4);
    end else if (pick < 72) begin
      // overlong form of a small value
      cp = (len == 2) ? 21'($urandom_range(0, 32'h7F))
         : (len == 3) ? 21'($urandom_range(0, 32'h7FF)) : 21'($urandom_range(0, 32'hFFFF));
      push_first(pack_seq(cp, len), len);
    end else if (pick < 76) begin
      push_first(pack_seq(21'($urandom_range(32'h10FFFF, 32'h13FFFF)), 4), 4);
    end else if (pick < 84) begin
      push_text(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      // truncated sequence cut by a byte that is not a continuation
      cp = (len == 2) ? 21'($urandom_range(32'h80, 32'h7FF))
         : (len == 3) ? 21'($urandom_range(32'h800, 32'hFFFF))
         : 21'($urandom_range(32'h10000, 32'h10FFFE));
      push_first(pack_seq(cp, len), $urandom_range(1, len - 1));
      b = 8'($urandom_range(0, 191));
      if (b >= 8'h80) b = b + 8'h40;
      push_text(b);
    end else begin
      push_text(8'h00);
    end
  endtask

  task automatic load_random(input int n);
    int start;
    start = text_bytes.size();
    while (text_bytes.size() - start < n) add_chunk();
  endtask

  // Wait until every byte went in and every predicted word came out.
  task automatic drain_all();
    while (text_bytes.size() != 0 || in_valid_i || words_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII, DEL and terminator; smallest two-byte point; private-use
    // point folding to an empty glyph; value at the upper limit; overlong
    // three-byte form; stray continuation and invalid lead; broken sequence;
    // terminator inside a sequence; four-byte point; surrogate.
    pace = PACE_FREE;
    text_bytes = {8'h41, 8'h7F, 8'h00,
                  8'hC2, 8'h80,
                  8'hEE, 8'h80, 8'h80,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF,
                  8'hE0, 8'h80, 8'h80,
                  8'h80, 8'hFF,
                  8'hC3, 8'h41,
                  8'hE2, 8'h82, 8'h00,
                  8'hF0, 8'h90, 8'h80, 8'h80,
                  8'hED, 8'hA0, 8'h80};
    drain_all();

    load_random(60);
    drain_all();

    pace = PACE_SEND_SPARSE;
    load_random(55);
    drain_all();

    pace = PACE_RECV_STALL;
    load_random(55);
    drain_all();

    pace = PACE_BOTH;
    load_random(60);
    drain_all();

    pace = PACE_HOLD;
    load_random(50);
    drain_all();

    $display("covered %0d text bytes in, %0d words out (%0d string ends, %0d high-bit bytes)",
             bytes_in, words_out, ends_seen, wide_words);
    $display("pacing: free-running, sparse sender, heavy stalls, mixed, long output hold-off");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ugs_pkg.sv
sv/ugs_front.sv
sv/ugs_queue.sv
sv/ugs_back.sv
sv/utf8_glyph_sanitizer.sv
sim/utf8_glyph_sanitizer_test.sv
